/* rtl/doh_pkg.sv */
// Package with phase codes, status codes and character helpers for the DoH parser.
`default_nettype none
package doh_pkg;

  typedef enum logic [4:0] {
    PH_VERSION    = 5'd0,
    PH_STATUS     = 5'd1,
    PH_HEADER     = 5'd2,
    PH_CONTENT    = 5'd3,
    PH_TYPE_NAME  = 5'd4,
    PH_LEN_NAME   = 5'd5,
    PH_TYPE_VALUE = 5'd6,
    PH_DNS_HEAD   = 5'd7,
    PH_QUERY      = 5'd8,
    PH_FIXED      = 5'd9,
    PH_SKIP       = 5'd10,
    PH_RDATA      = 5'd11,
    PH_DONE       = 5'd12,
    PH_ERROR      = 5'd16
  } phase_t;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_CODE    = 3'd3;
  localparam logic [2:0] ST_HEADER  = 3'd4;
  localparam logic [2:0] ST_TYPE    = 3'd5;
  localparam logic [2:0] ST_LENGTH  = 3'd6;
  localparam logic [2:0] ST_QUERY   = 3'd7;

  localparam logic [15:0] TYPE_A    = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        rdata_valid;
    logic [7:0]  rdata_byte;
    logic        rdata_last;
    logic [15:0] answer_index;
    logic [15:0] answer_type;
    logic [15:0] content_length;
  } out_item_t;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    lower_of = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] tx_http(input logic [4:0] i);
    case (i)
      5'd0: tx_http = "H";
      5'd1: tx_http = "T";
      5'd2: tx_http = "T";
      5'd3: tx_http = "P";
      default: tx_http = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tx_code(input logic [4:0] i);
    case (i)
      5'd0: tx_code = "2";
      5'd1: tx_code = "0";
      5'd2: tx_code = "0";
      default: tx_code = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tx_content(input logic [4:0] i);
    case (i)
      5'd0: tx_content = 8'h0D;
      5'd1: tx_content = 8'h0A;
      5'd2: tx_content = "C";
      5'd3: tx_content = "O";
      5'd4: tx_content = "N";
      5'd5: tx_content = "T";
      5'd6: tx_content = "E";
      5'd7: tx_content = "N";
      5'd8: tx_content = "T";
      5'd9: tx_content = "-";
      default: tx_content = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tx_type(input logic [4:0] i);
    case (i)
      5'd0: tx_type = "T";
      5'd1: tx_type = "Y";
      5'd2: tx_type = "P";
      5'd3: tx_type = "E";
      5'd4: tx_type = ":";
      default: tx_type = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tx_len(input logic [4:0] i);
    case (i)
      5'd0: tx_len = "L";
      5'd1: tx_len = "E";
      5'd2: tx_len = "N";
      5'd3: tx_len = "G";
      5'd4: tx_len = "T";
      5'd5: tx_len = "H";
      5'd6: tx_len = ":";
      default: tx_len = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tx_msg(input logic [4:0] i);
    case (i)
      5'd0:  tx_msg = "a";
      5'd1:  tx_msg = "p";
      5'd2:  tx_msg = "p";
      5'd3:  tx_msg = "l";
      5'd4:  tx_msg = "i";
      5'd5:  tx_msg = "c";
      5'd6:  tx_msg = "a";
      5'd7:  tx_msg = "t";
      5'd8:  tx_msg = "i";
      5'd9:  tx_msg = "o";
      5'd10: tx_msg = "n";
      5'd11: tx_msg = "/";
      5'd12: tx_msg = "d";
      5'd13: tx_msg = "n";
      5'd14: tx_msg = "s";
      5'd15: tx_msg = "-";
      5'd16: tx_msg = "m";
      5'd17: tx_msg = "e";
      5'd18: tx_msg = "s";
      5'd19: tx_msg = "s";
      5'd20: tx_msg = "a";
      5'd21: tx_msg = "g";
      5'd22: tx_msg = "e";
      default: tx_msg = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tx_end(input logic [2:0] i);
    case (i)
      3'd0: tx_end = 8'h0D;
      3'd1: tx_end = 8'h0A;
      3'd2: tx_end = 8'h0D;
      3'd3: tx_end = 8'h0A;
      default: tx_end = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/doh_stream_if.sv */
// Valid/ready stream interface carrying one payload word.
`default_nettype none
interface doh_stream_if #(
  parameter int unsigned W = 8
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/doh_parse_core.sv */
// Per-byte parser state update and result formation.
`default_nettype none
module doh_parse_core
  import doh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire in_item_t    item,
  input  wire logic [15:0] query_length,
  output out_item_t        result
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  match_r, match_nxt;
  logic [2:0]  endc_r, endc_nxt;
  logic        type_seen_r, type_seen_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] qseen_r, qseen_nxt;
  logic [3:0]  ffp_r, ffp_nxt;
  logic [15:0] atot_r, atot_nxt;
  logic [15:0] adone_r, adone_nxt;
  logic [15:0] kept_r, kept_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [15:0] dpos_r, dpos_nxt;

  always_comb begin
    phase_t      ph;
    logic [4:0]  mp;
    logic [2:0]  ec;
    logic        ts;
    logic [15:0] lv, qs, at, ad, ki, rt, dl, dp;
    logic [3:0]  fp;
    logic [7:0]  b;
    logic [19:0] lsum;
    logic        keep;
    logic [15:0] adinc;
    b  = item.data_byte;
    ph = phase_r; mp = match_r; ec = endc_r; ts = type_seen_r;
    lv = len_r; qs = qseen_r; fp = ffp_r; at = atot_r; ad = adone_r;
    ki = kept_r; rt = rtype_r; dl = dlen_r; dp = dpos_r;
    lsum = '0; keep = 1'b0;
    adinc = adone_r + 16'd1;
    result = '0;
    if (item.first) begin
      ph = PH_VERSION; mp = '0; ec = '0; ts = 1'b0; lv = '0; qs = '0; fp = '0;
      at = '0; ad = '0; ki = '0; rt = '0; dl = '0; dp = '0;
      adinc = 16'd1;
    end
    case (ph)
      PH_VERSION: begin
        if (mp >= 5'd4) begin
          if (b == " ") begin mp = '0; ph = PH_STATUS; end
        end else if (tx_http(mp) != b) ph = phase_t'(PH_ERROR + 5'(ST_VERSION));
        else mp = mp + 5'd1;
      end
      PH_STATUS: begin
        if (mp >= 5'd3) begin
          if (b == " ") begin mp = '0; ph = PH_HEADER; end
          else ph = phase_t'(PH_ERROR + 5'(ST_CODE));
        end else if (tx_code(mp) != b) ph = phase_t'(PH_ERROR + 5'(ST_CODE));
        else mp = mp + 5'd1;
      end
      PH_HEADER: begin
        if (mp < 5'd10 && lower_of(tx_content(mp)) == lower_of(b)) begin
          mp = mp + 5'd1;
          if (mp >= 5'd10) begin mp = '0; ph = PH_CONTENT; end
        end else mp = '0;
        if (ec < 3'd4 && tx_end(ec) == b) begin
          ec = ec + 3'd1;
          if (ec >= 3'd4) begin
            if (lv != 16'd0 && ts) begin
              ec = '0; fp = '0; qs = '0; ph = PH_DNS_HEAD;
            end else ph = phase_t'(PH_ERROR + 5'(ST_HEADER));
          end
        end else ec = '0;
      end
      PH_CONTENT: begin
        if (lower_of(b) == "t") begin ph = PH_TYPE_NAME; mp = 5'd1; end
        else if (lower_of(b) == "l") begin ph = PH_LEN_NAME; mp = 5'd1; end
        else begin ph = PH_HEADER; mp = '0; end
      end
      PH_TYPE_NAME: begin
        if (mp < 5'd5 && lower_of(tx_type(mp)) == lower_of(b)) begin
          mp = mp + 5'd1;
          if (mp >= 5'd5) begin mp = '0; ph = PH_TYPE_VALUE; end
        end else begin mp = '0; ph = PH_HEADER; end
      end
      PH_LEN_NAME: begin
        if (mp < 5'd7) begin
          if (lower_of(tx_len(mp)) != lower_of(b)) begin mp = '0; ph = PH_HEADER; end
          else mp = mp + 5'd1;
        end else if (b >= "0" && b <= "9") begin
          // Times ten as two shifts; the sum fits 20 bits before saturating.
          lsum = {1'b0, lv, 3'b0} + {3'b0, lv, 1'b0} + {12'd0, b - 8'h30};
          lv = (lsum > 20'hFFFF) ? 16'hFFFF : lsum[15:0];
        end else if (b == 8'h0D) begin
          ec = ec + 3'd1; mp = 5'd1; ph = PH_HEADER;
        end else if (b != " ") ph = phase_t'(PH_ERROR + 5'(ST_LENGTH));
      end
      PH_TYPE_VALUE: begin
        if (b != " " || (mp > 5'd0 && mp < 5'd23)) begin
          if (mp < 5'd23) begin
            if (b != tx_msg(mp)) ph = phase_t'(PH_ERROR + 5'(ST_TYPE));
            else mp = mp + 5'd1;
          end else if (b == 8'h0D) begin
            mp = 5'd1; ec = ec + 3'd1; ts = 1'b1; ph = PH_HEADER;
          end else ph = phase_t'(PH_ERROR + 5'(ST_TYPE));
        end
      end
      PH_DNS_HEAD: begin
        if (fp == 4'd6 || fp == 4'd7) at = {at[7:0], b};
        fp = fp + 4'd1;
        if (fp >= 4'd8) begin
          fp = '0;
          ph = (at == 16'd0) ? PH_DONE : PH_QUERY;
        end
        if (qs >= query_length) ph = phase_t'(PH_ERROR + 5'(ST_QUERY));
        else qs = qs + 16'd1;
      end
      PH_QUERY: begin
        qs = qs + 16'd1;
        if (qs >= query_length) begin
          ph = PH_FIXED; fp = '0; rt = '0; dl = '0;
        end
      end
      PH_FIXED: begin
        if (fp == 4'd2 || fp == 4'd3) rt = {rt[7:0], b};
        if (fp == 4'd10 || fp == 4'd11) dl = {dl[7:0], b};
        fp = fp + 4'd1;
        if (fp >= 4'd12) begin
          keep = (rt == TYPE_A) || (rt == TYPE_AAAA);
          fp = '0; dp = '0;
          if (dl == 16'd0) begin
            if (keep) ki = ki + 16'd1;
            ad = adinc;
            if (adinc >= at) ph = PH_DONE;
            else begin ph = PH_FIXED; rt = '0; dl = '0; end
          end else ph = keep ? PH_RDATA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        dp = dp + 16'd1;
        if (dp >= dl) begin
          ad = adinc;
          if (adinc >= at) ph = PH_DONE;
          else begin ph = PH_FIXED; fp = '0; rt = '0; dl = '0; end
        end
      end
      PH_RDATA: begin
        result.rdata_valid  = 1'b1;
        result.rdata_byte   = b;
        result.answer_index = ki;
        result.answer_type  = rt;
        dp = dp + 16'd1;
        if (dp >= dl) begin
          result.rdata_last = 1'b1;
          ki = ki + 16'd1;
          ad = adinc;
          if (adinc >= at) ph = PH_DONE;
          else begin ph = PH_FIXED; fp = '0; rt = '0; dl = '0; end
        end
      end
      default: ;
    endcase
    if (ph[4]) result.status = ph[2:0];
    else if (ph == PH_DONE) result.status = ST_DONE;
    else result.status = ST_BUSY;
    result.content_length = lv;
    phase_nxt = ph; match_nxt = mp; endc_nxt = ec; type_seen_nxt = ts;
    len_nxt = lv; qseen_nxt = qs; ffp_nxt = fp; atot_nxt = at; adone_nxt = ad;
    kept_nxt = ki; rtype_nxt = rt; dlen_nxt = dl; dpos_nxt = dp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VERSION; match_r <= '0; endc_r <= '0; type_seen_r <= 1'b0;
      len_r <= '0; qseen_r <= '0; ffp_r <= '0; atot_r <= '0; adone_r <= '0;
      kept_r <= '0; rtype_r <= '0; dlen_r <= '0; dpos_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; match_r <= match_nxt; endc_r <= endc_nxt;
      type_seen_r <= type_seen_nxt; len_r <= len_nxt; qseen_r <= qseen_nxt;
      ffp_r <= ffp_nxt; atot_r <= atot_nxt; adone_r <= adone_nxt;
      kept_r <= kept_nxt; rtype_r <= rtype_nxt; dlen_r <= dlen_nxt;
      dpos_r <= dpos_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/doh_response_byte_parser_top.sv */
// Top level of the DNS-over-HTTPS response byte parser.
// Channels: in (data_byte, first) carries response bytes, one per transfer;
// out carries one result per input byte (status, rdata fields, content_length);
// cfg writes the 16-bit query_length register; the user must write it only while
// the parser is idle, since the block itself does not enforce this. Each input
// byte is registered, processed by the parser core once the output register can
// take its result, and its result lands in a one-entry output register.
// Throughput is one byte per cycle while the receiver does not stall.
// The input register refills while the output register drains in the same
// cycle, so back-to-back bytes flow with no bubble.
// When the receiver stalls, the output register holds and the input register
// then holds its byte; in_ready falls only when both are full and blocked.
// Reset clears all parse state, the query_length register and both valid
// flags; a byte with first set restarts parsing at any time.
`default_nettype none
module doh_response_byte_parser_top
  import doh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  doh_stream_if.sink   in_ch,
  doh_stream_if.source out_ch,
  doh_stream_if.sink   cfg_ch
);

  logic [15:0] query_length_r;
  in_item_t    in_r;
  logic        in_vld_r;
  out_item_t   out_r;
  logic        out_vld_r;
  out_item_t   core_res;
  logic        step;

  assign cfg_ch.ready = 1'b1;
  assign step         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_r;

  doh_parse_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (in_r),
    .query_length (query_length_r),
    .result       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_length_r <= '0;
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid) query_length_r <= cfg_ch.payload[15:0];
      if (in_ch.valid && in_ch.ready) in_vld_r <= 1'b1;
      else if (step) in_vld_r <= 1'b0;
      if (step) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_r <= in_item_t'(in_ch.payload);
    if (step) out_r <= core_res;
  end

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the DNS-over-HTTPS response byte parser.
`timescale 1ns / 1ps
`default_nettype none
module testbench
  import doh_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned MAX_PRINTS = 40;

  logic clk;
  logic rst_n;

  doh_stream_if #(.W(9)) in_ch ();
  doh_stream_if #(.W(61)) out_ch ();
  doh_stream_if #(.W(16)) cfg_ch ();

  doh_response_byte_parser_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Parser mirror state.
  logic [15:0] query_len;
  logic [4:0]  phase;
  int unsigned mpos, end_cnt, type_ok, clen, qseen, fpos;
  int unsigned an_total, an_done, kept, rtype, rdlen, dpos;

  out_item_t   result_q[$];
  logic [7:0]  stream_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned burst_left;

  string k_http = "HTTP";
  string k_code = "200";
  string k_content = "\015\012CONTENT-";
  string k_type = "TYPE:";
  string k_len = "LENGTH:";
  string k_msg = "application/dns-message";
  string k_end = "\015\012\015\012";

  function automatic logic [7:0] lc(input logic [7:0] c);
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void clear_parse();
    phase = PH_VERSION;
    mpos = 0; end_cnt = 0; type_ok = 0; clen = 0; qseen = 0; fpos = 0;
    an_total = 0; an_done = 0; kept = 0; rtype = 0; rdlen = 0; dpos = 0;
  endfunction

  function automatic void fail_with(input logic [2:0] code);
    phase = 5'(PH_ERROR) + 5'(code);
  endfunction

  function automatic void close_answer();
    an_done = (an_done + 1) & 16'hFFFF;
    if (an_done >= an_total) begin
      phase = PH_DONE;
    end else begin
      phase = PH_FIXED;
      fpos = 0; rtype = 0; rdlen = 0;
    end
  endfunction

  function automatic void scan_header(input logic [7:0] b);
    if (mpos < 10 && lc(k_content[mpos]) == lc(b)) begin
      mpos++;
      if (mpos >= 10) begin
        mpos = 0; phase = PH_CONTENT;
      end
    end else begin
      mpos = 0;
    end
    if (end_cnt < 4 && k_end[end_cnt] == b) begin
      end_cnt++;
      if (end_cnt >= 4) begin
        if (clen != 0 && type_ok != 0) begin
          end_cnt = 0; fpos = 0; qseen = 0; phase = PH_DNS_HEAD;
        end else begin
          fail_with(ST_HEADER);
        end
      end
    end else begin
      end_cnt = 0;
    end
  endfunction

  // Computes the result of one byte and advances the mirror state.
  function automatic out_item_t parse_byte(input logic [7:0] b, input logic restart);
    out_item_t r;
    logic keep;
    r = '0;
    if (restart) clear_parse();
    case (phase)
      PH_VERSION: begin
        if (mpos >= 4) begin
          if (b == " ") begin
            mpos = 0; phase = PH_STATUS;
          end
        end else if (k_http[mpos] != b) fail_with(ST_VERSION);
        else mpos++;
      end
      PH_STATUS: begin
        if (mpos >= 3) begin
          if (b == " ") begin
            mpos = 0; phase = PH_HEADER;
          end else fail_with(ST_CODE);
        end else if (k_code[mpos] != b) fail_with(ST_CODE);
        else mpos++;
      end
      PH_HEADER: scan_header(b);
      PH_CONTENT: begin
        if (lc(b) == "t") begin
          phase = PH_TYPE_NAME; mpos = 1;
        end else if (lc(b) == "l") begin
          phase = PH_LEN_NAME; mpos = 1;
        end else begin
          phase = PH_HEADER; mpos = 0;
        end
      end
      PH_TYPE_NAME: begin
        if (mpos < 5 && lc(k_type[mpos]) == lc(b)) begin
          mpos++;
          if (mpos >= 5) begin
            mpos = 0; phase = PH_TYPE_VALUE;
          end
        end else begin
          mpos = 0; phase = PH_HEADER;
        end
      end
      PH_LEN_NAME: begin
        if (mpos < 7) begin
          if (lc(k_len[mpos]) != lc(b)) begin
            mpos = 0; phase = PH_HEADER;
          end else mpos++;
        end else if (b >= "0" && b <= "9") begin
          clen = clen * 10 + (b - "0");
          if (clen > 16'hFFFF) clen = 16'hFFFF;
        end else if (b == 8'h0D) begin
          end_cnt = (end_cnt + 1) & 7;
          mpos = 1; phase = PH_HEADER;
        end else if (b != " ") fail_with(ST_LENGTH);
      end
      PH_TYPE_VALUE: begin
        if (b != " " || (mpos > 0 && mpos < 23)) begin
          if (mpos < 23) begin
            if (b != k_msg[mpos]) fail_with(ST_TYPE);
            else mpos++;
          end else if (b == 8'h0D) begin
            mpos = 1;
            end_cnt = (end_cnt + 1) & 7;
            type_ok = 1; phase = PH_HEADER;
          end else fail_with(ST_TYPE);
        end
      end
      PH_DNS_HEAD: begin
        if (fpos == 6 || fpos == 7) an_total = ((an_total << 8) | b) & 16'hFFFF;
        fpos = (fpos + 1) & 15;
        if (fpos >= 8) begin
          fpos = 0;
          phase = (an_total == 0) ? PH_DONE : PH_QUERY;
        end
        if (qseen >= query_len) fail_with(ST_QUERY);
        else qseen = (qseen + 1) & 16'hFFFF;
      end
      PH_QUERY: begin
        qseen = (qseen + 1) & 16'hFFFF;
        if (qseen >= query_len) begin
          phase = PH_FIXED; fpos = 0; rtype = 0; rdlen = 0;
        end
      end
      PH_FIXED: begin
        if (fpos == 2 || fpos == 3) rtype = ((rtype << 8) | b) & 16'hFFFF;
        if (fpos == 10 || fpos == 11) rdlen = ((rdlen << 8) | b) & 16'hFFFF;
        fpos = (fpos + 1) & 15;
        if (fpos >= 12) begin
          keep = (rtype == TYPE_A || rtype == TYPE_AAAA);
          fpos = 0; dpos = 0;
          if (rdlen == 0) begin
            if (keep) kept = (kept + 1) & 16'hFFFF;
            close_answer();
          end else begin
            phase = keep ? PH_RDATA : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        dpos = (dpos + 1) & 16'hFFFF;
        if (dpos >= rdlen) close_answer();
      end
      PH_RDATA: begin
        r.rdata_valid = 1'b1;
        r.rdata_byte = b;
        r.answer_index = kept[15:0];
        r.answer_type = rtype[15:0];
        dpos = (dpos + 1) & 16'hFFFF;
        if (dpos >= rdlen) begin
          r.rdata_last = 1'b1;
          kept = (kept + 1) & 16'hFFFF;
          close_answer();
        end
      end
      default: ;
    endcase
    if (phase >= 5'(PH_ERROR)) r.status = 3'(phase - 5'(PH_ERROR));
    else r.status = (phase == PH_DONE) ? ST_DONE : ST_BUSY;
    r.content_length = clen[15:0];
    return r;
  endfunction

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH %s: expected %0d, got %0d at cycle %0d", what, want, got, cycles);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    out_item_t got, want;
    int unsigned mode;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_item_t'(out_ch.payload);
      if (result_q.size() == 0) begin
        report("unexpected result", 0, 1);
      end else begin
        want = result_q.pop_front();
        if (got.status != want.status) report("status", want.status, got.status);
        if (got.rdata_valid != want.rdata_valid)
          report("rdata_valid", want.rdata_valid, got.rdata_valid);
        if (got.rdata_byte != want.rdata_byte)
          report("rdata_byte", want.rdata_byte, got.rdata_byte);
        if (got.rdata_last != want.rdata_last)
          report("rdata_last", want.rdata_last, got.rdata_last);
        if (got.answer_index != want.answer_index)
          report("answer_index", want.answer_index, got.answer_index);
        if (got.answer_type != want.answer_type)
          report("answer_type", want.answer_type, got.answer_type);
        if (got.content_length != want.content_length)
          report("content_length", want.content_length, got.content_length);
      end
    end
    // The stall behavior steps through four modes as the cycle counter advances.
    mode = (cycles >> 8) % 4;
    case (mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(3) != 0);
      2: out_ch.ready <= $urandom_range(1);
      default: out_ch.ready <= ((cycles % 7) < 2);
    endcase
  end

  // One byte transfer; the sender may idle between bursts of random length.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    in_item_t item;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    item.data_byte = b;
    item.first = restart;
    in_ch.valid <= 1'b1;
    in_ch.payload <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    result_q.push_back(parse_byte(b, restart));
    items_sent++;
  endtask

  task automatic flush_stream();
    logic restart;
    restart = 1'b1;
    while (stream_q.size() != 0) begin
      send_byte(stream_q.pop_front(), restart);
      restart = 1'b0;
    end
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_query_len(input logic [15:0] v);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    query_len = v;
  endtask

  task automatic add_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
      stream_q.push_back(c);
    end
  endtask

  task automatic add_http_head(input string len_text, input string type_text);
    add_text("HTTP/1.1 200 OK\015\012", 1'b0);
    add_text("content-type: ", 1'b1);
    add_text({type_text, "\015\012"}, 1'b0);
    add_text("server: x\015\012content-length: ", 1'b1);
    add_text({len_text, "\015\012\015\012"}, 1'b0);
  endtask

  task automatic add_dns_head(input int unsigned answers);
    repeat (6) stream_q.push_back(8'($urandom));
    stream_q.push_back(8'(answers >> 8));
    stream_q.push_back(8'(answers));
    for (int i = 8; i < query_len; i++) stream_q.push_back(8'($urandom));
  endtask

  task automatic add_answer(input logic [15:0] rt, input logic [15:0] len);
    stream_q.push_back(8'hC0);
    stream_q.push_back(8'h0C);
    stream_q.push_back(rt[15:8]);
    stream_q.push_back(rt[7:0]);
    repeat (6) stream_q.push_back(8'($urandom));
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    repeat (len) stream_q.push_back(8'($urandom));
  endtask

  task automatic test_good_response();
    write_query_len(16'd12);
    add_http_head("120", "application/dns-message");
    add_dns_head(3);
    add_answer(TYPE_A, 16'd4);
    add_answer(16'd5, 16'd3);
    add_answer(TYPE_AAAA, 16'd16);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h00);
    flush_stream();
  endtask

  task automatic test_empty_and_no_answers();
    add_http_head("65", "application/dns-message");
    add_dns_head(2);
    add_answer(TYPE_A, 16'd0);
    add_answer(TYPE_AAAA, 16'd1);
    flush_stream();
    add_http_head("999999", "application/dns-message");
    add_dns_head(0);
    stream_q.push_back(8'h55);
    flush_stream();
  endtask

  task automatic test_header_errors();
    add_text("HXTP", 1'b0);
    flush_stream();
    add_text("HTTP/2 201 ", 1'b0);
    flush_stream();
    add_text("HTTP 2000", 1'b0);
    flush_stream();
    add_http_head("0", "application/dns-message");
    flush_stream();
    add_text("HTTP/1.1 200 OK\015\012\015\012", 1'b0);
    flush_stream();
    add_http_head("12", "text/html");
    flush_stream();
    add_http_head("1x2", "application/dns-message");
    flush_stream();
  endtask

  task automatic test_short_query();
    write_query_len(16'd0);
    add_http_head("40", "application/dns-message");
    add_dns_head(1);
    flush_stream();
    write_query_len(16'd5);
    add_http_head("40", "application/dns-message");
    add_dns_head(1);
    flush_stream();
    write_query_len(16'hFFFF);
    add_http_head("40", "application/dns-message");
    repeat (40) stream_q.push_back(8'($urandom));
    flush_stream();
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    logic [15:0] rt;
    while (items_sent < 1600) begin
      if ($urandom_range(5) == 0) write_query_len(16'($urandom_range(8, 30)));
      case ($urandom_range(9))
        0: begin
          // Noise with random restarts.
          n = $urandom_range(5, 40);
          for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(7) == 0);
          in_ch.valid <= 1'b0;
          burst_left = 0;
          @(posedge clk);
        end
        1: begin
          // A good response cut short and restarted.
          add_http_head($sformatf("%0d", $urandom_range(1, 2000)), "application/dns-message");
          add_dns_head(2);
          add_answer(TYPE_A, 16'd4);
          n = $urandom_range(1, stream_q.size() - 1);
          while (stream_q.size() > n) void'(stream_q.pop_back());
          flush_stream();
        end
        default: begin
          add_http_head($sformatf("%0d", $urandom_range(1, 99999)), "application/dns-message");
          n = $urandom_range(0, 4);
          add_dns_head(n);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
              0: rt = TYPE_A;
              1: rt = TYPE_AAAA;
              2: rt = 16'($urandom);
              default: rt = 16'd5;
            endcase
            add_answer(rt, 16'($urandom_range(0, 20)));
          end
          repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom));
          flush_stream();
        end
      endcase
    end
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    query_len = '0;
    clear_parse();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_response();
    test_empty_and_no_answers();
    test_header_errors();
    test_short_query();
    test_random_traffic();
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
